### sv/wide_integer_power_top_assert.svh
// Assertion macros for the wide integer power block
`ifndef WIDE_INTEGER_POWER_TOP_ASSERT_SVH
`define WIDE_INTEGER_POWER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WIP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WIP_ASSERT(label, prop, msg)
`define WIP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### sv/wip_pkg.sv
// Package with types and constants of the wide integer power block
package wip_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned ExpW = 16;
	localparam int unsigned IdxW = 6;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_NEXT,
		ST_MUL,
		ST_DRAIN,
		ST_COPY,
		ST_OUT
	} wip_state_t;
endpackage

### sv/wip_if.sv
// Valid/ready channel interfaces of the wide integer power block
interface wip_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] base_word;
	logic [15:0] exponent;
	modport source (output valid, base_word, exponent, input ready);
	modport sink (input valid, base_word, exponent, output ready);
endinterface

interface wip_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  word_index;
	logic [31:0] word_value;
	logic        last_word;
	modport source (output valid, word_index, word_value, last_word, input ready);
	modport sink (input valid, word_index, word_value, last_word, output ready);
endinterface

### sv/wip_ram.sv
// Generic single-port-write, single-read RAM with registered read data
module wip_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### sv/wide_integer_power_top.sv
// Top level of the wide integer power block
// Raises a 32-bit base to a 16-bit power modulo 2^(32*WORDS) by right-to-left
// square-and-multiply through one shared 32x32 multiplier. The partial power, two copies
// of the running base and the product being formed sit in four RAMs of WORDS words. A
// request is accepted only while idle, and the operands are then loaded word by word.
// Each truncated product issues its WORDS*(WORDS+1)/2 word multiplies column by column,
// one per cycle, then drains the multiply pipeline, copies the product back and picks the
// next step. An exponent with n significant bits, m of them set, needs m multiplies and
// n-1 squarings, at most 31 products; then the result's WORDS words go out, least
// significant first, one per cycle while the receiver is ready.
`include "wide_integer_power_top_assert.svh"
module wide_integer_power_top
	import wip_pkg::*;
#(
	parameter int unsigned WORDS = 36
) (
	input  logic      clk,
	input  logic      arst_n,
	wip_in_if.sink    in_ch,
	wip_out_if.source out_ch
);
	localparam int unsigned AW = $clog2(WORDS);
	localparam int unsigned ColW = 2 * WordW + 8;

	wip_state_t         state_q, state_d;
	logic [WordW-1:0]   base_in_q;
	logic [ExpW-1:0]    exp_q;
	logic               sq_q;
	logic [AW-1:0]      k_q, i_q;
	logic [AW-1:0]      k_nx, b_ra, wa_w, acc_ra;
	logic               last_k;
	logic               v_s1, end_s1, cp_s1, sq_s1;
	logic [AW-1:0]      k_s1;
	logic               v_s2, end_s2;
	logic [AW-1:0]      k_s2;
	logic [2*WordW-1:0] mul_s2;
	logic [ColW-1:0]    col_q;
	logic [ColW-1:0]    sum_w;
	logic [WordW-1:0]   a_w;
	logic               init_we, acc_we, base_we, prod_we;
	logic [WordW-1:0]   acc_wd, base_wd;
	logic [WordW-1:0]   acc_rd, base_a_rd, base_b_rd, prod_rd;
	logic               out_stall;

	assign last_k  = (k_q == AW'(WORDS - 1));
	assign k_nx    = last_k ? '0 : k_q + 1'b1;
	assign b_ra    = k_q - i_q;
	assign a_w     = sq_q ? base_a_rd : acc_rd;
	assign sum_w   = col_q + ColW'(mul_s2);
	assign init_we = (state_q == ST_INIT);
	assign acc_we  = init_we || (cp_s1 && !sq_s1);
	assign base_we = init_we || (cp_s1 && sq_s1);
	assign prod_we = v_s2 && end_s2;
	assign wa_w    = init_we ? k_q : k_s1;
	assign acc_wd  = init_we ? ((k_q == '0) ? WordW'(1) : '0) : prod_rd;
	assign base_wd = init_we ? ((k_q == '0) ? base_in_q : '0) : prod_rd;
	assign acc_ra  = (state_q == ST_MUL) ? i_q :
		((out_ch.valid && out_ch.ready) ? k_nx : k_q);
	assign out_stall = out_ch.valid && !out_ch.ready;

	assign out_ch.word_index = IdxW'(k_q);
	assign out_ch.word_value = acc_rd;
	assign out_ch.last_word  = last_k;

	wip_ram #(.WIDTH(WordW), .DEPTH(WORDS)) u_acc (
		.clk(clk), .we(acc_we), .waddr(wa_w), .wdata(acc_wd), .raddr(acc_ra),
		.rdata(acc_rd));
	wip_ram #(.WIDTH(WordW), .DEPTH(WORDS)) u_base_a (
		.clk(clk), .we(base_we), .waddr(wa_w), .wdata(base_wd), .raddr(i_q),
		.rdata(base_a_rd));
	wip_ram #(.WIDTH(WordW), .DEPTH(WORDS)) u_base_b (
		.clk(clk), .we(base_we), .waddr(wa_w), .wdata(base_wd), .raddr(b_ra),
		.rdata(base_b_rd));
	wip_ram #(.WIDTH(WordW), .DEPTH(WORDS)) u_prod (
		.clk(clk), .we(prod_we), .waddr(k_s2), .wdata(sum_w[WordW-1:0]), .raddr(k_q),
		.rdata(prod_rd));

	always_comb begin
		state_d      = state_q;
		in_ch.ready  = 1'b0;
		out_ch.valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = ST_INIT;
			end
			ST_INIT:  if (last_k) state_d = ST_NEXT;
			ST_NEXT:  state_d = (exp_q == '0) ? ST_OUT : ST_MUL;
			ST_MUL:   if (last_k && i_q == k_q) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1) state_d = ST_COPY;
			ST_COPY:  if (last_k) state_d = ST_NEXT;
			ST_OUT: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready && last_k) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_in_q <= '0;
			exp_q     <= '0;
			sq_q      <= 1'b0;
			k_q       <= '0;
			i_q       <= '0;
			v_s1      <= 1'b0;
			end_s1    <= 1'b0;
			cp_s1     <= 1'b0;
			sq_s1     <= 1'b0;
			k_s1      <= '0;
			v_s2      <= 1'b0;
			end_s2    <= 1'b0;
			k_s2      <= '0;
			mul_s2    <= '0;
			col_q     <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_MUL);
			end_s1  <= (i_q == k_q);
			cp_s1   <= (state_q == ST_COPY);
			sq_s1   <= sq_q;
			k_s1    <= k_q;
			v_s2    <= v_s1;
			end_s2  <= end_s1;
			k_s2    <= k_s1;
			mul_s2  <= 64'(a_w) * 64'(base_b_rd);
			if (state_q == ST_NEXT) begin
				col_q <= '0;
			end else if (v_s2) begin
				col_q <= end_s2 ? (sum_w >> WordW) : sum_w;
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (in_ch.valid) begin
						base_in_q <= in_ch.base_word;
						exp_q     <= in_ch.exponent;
						sq_q      <= 1'b0;
					end
				end
				ST_INIT: k_q <= k_nx;
				ST_NEXT: begin
					k_q <= '0;
					i_q <= '0;
					if (exp_q != '0) sq_q <= sq_q | ~exp_q[0];
				end
				ST_MUL: begin
					if (i_q == k_q) begin
						i_q <= '0;
						k_q <= k_nx;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_COPY: begin
					k_q <= k_nx;
					if (last_k) begin
						if (sq_q || exp_q <= ExpW'(1)) begin
							exp_q <= exp_q >> 1;
							sq_q  <= 1'b0;
						end else begin
							sq_q <= 1'b1;
						end
					end
				end
				ST_OUT: if (out_ch.ready) k_q <= k_nx;
				default: ;
			endcase
		end
	end

	`WIP_ASSERT(a_busy_not_ready, (state_q != ST_IDLE) |-> !in_ch.ready, "ready while busy")
	`WIP_ASSERT(a_out_only_done, out_ch.valid |-> (exp_q == '0), "output before done")
	`WIP_ASSERT_NEXT(a_out_hold, out_stall, $stable(k_q) && $stable(acc_rd), "stall moved word")
	`WIP_ASSERT(a_row_in_column, (state_q == ST_MUL) |-> (i_q <= k_q), "row beyond column")
endmodule
